>>> src/cuwm_pkg.sv
// Shared types, constants and helpers for the card identifier whitelist
package cuwm_pkg;

	localparam int CUWM_ENTRIES = 64;

	localparam int SLOT_W    = 6;
	localparam int LEN_W     = 4;
	localparam int UID_W     = 64;
	localparam int STATUS_W  = 2;
	localparam int UID_BYTES = UID_W / 8;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 8;

	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_ENROLL = 1'b1;

	localparam logic [LEN_W-1:0] LEN_SHORT  = 4'd4;
	localparam logic [LEN_W-1:0] LEN_DOUBLE = 4'd7;
	localparam logic [LEN_W-1:0] LEN_EIGHT  = 4'd8;

	localparam logic [STATUS_W-1:0] STATUS_NOMATCH  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ENROLLED = 2'd2;

	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [UID_W-1:0] uid;
	} chain_t;

	function automatic logic [UID_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [UID_W-1:0] m;
		m = '0;
		for (int b = 0; b < UID_BYTES; b++) begin
			m[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

>>> src/cuwm_cell.sv
// One whitelist entry with its stage of the query chain
module cuwm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [cuwm_pkg::LEN_W-1:0] wr_length,
	input  logic [cuwm_pkg::UID_W-1:0] wr_uid,
	input  cuwm_pkg::chain_t           chain_in,
	output cuwm_pkg::chain_t           chain_out
);
	import cuwm_pkg::*;

	logic             valid_q;
	logic [LEN_W-1:0] length_q;
	logic [UID_W-1:0] uid_q;
	logic             vld_q;
	logic             hit_q;
	logic [UID_W-1:0] qry_uid_q;
	logic             len_ok;
	logic             hit;

	always_comb begin
		len_ok = (length_q == LEN_SHORT) || (length_q == LEN_DOUBLE) ||
			(length_q == LEN_EIGHT);
		hit = valid_q && len_ok &&
			(((chain_in.uid ^ uid_q) & byte_mask(length_q)) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q <= 1'b1;
			end
			vld_q <= chain_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			length_q <= wr_length;
			uid_q    <= wr_uid;
		end
		hit_q     <= chain_in.hit | hit;
		qry_uid_q <= chain_in.uid;
	end

	always_comb begin
		chain_out.vld = vld_q;
		chain_out.hit = hit_q;
		chain_out.uid = qry_uid_q;
	end

endmodule

>>> src/card_uid_whitelist_match.sv
// Top level of the card identifier whitelist: slave port, cell chain, verdict register
// Enroll: writes the slot at acceptance; status 2 shows in the cycle after acceptance.
// Check: the identifier walks the row of ENTRIES cells, one cell per cycle; the
// verdict of a last item is registered from the chain tail into the output register.
// One item at a time: a check holds the input until it leaves the chain tail.
// Reset clears every valid mark, the group flag and the output register.
module card_uid_whitelist_match #(
	parameter int ENTRIES = cuwm_pkg::CUWM_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// opcode [0], slot [6:1], uid_length [10:7], uid_bytes [74:11], zero [79:75]
	input  logic [cuwm_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status [1:0], zero [7:2]
	output logic [cuwm_pkg::M_TDATA_W-1:0] m_tdata
);
	import cuwm_pkg::*;

	logic                opcode;
	logic [SLOT_W-1:0]   slot;
	logic [LEN_W-1:0]    uid_length;
	logic [UID_W-1:0]    uid_bytes;
	logic [UID_W-1:0]    wr_uid;
	logic                accept;
	logic                busy_q;
	logic                last_q;
	logic                group_q;
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ENTRIES-1:0]  wr_en;
	chain_t              chain [ENTRIES+1];
	chain_t              tail;

	always_comb begin
		opcode     = s_tdata[0];
		slot       = s_tdata[SLOT_W:1];
		uid_length = s_tdata[SLOT_W+LEN_W:SLOT_W+1];
		uid_bytes  = s_tdata[SLOT_W+LEN_W+UID_W:SLOT_W+LEN_W+1];
		wr_uid     = uid_bytes & byte_mask(uid_length);
		s_tready   = !busy_q && (!m_tvalid_q || m_tready);
		accept     = s_tvalid && s_tready;
	end

	assign chain[0].vld = accept && (opcode == OP_CHECK);
	assign chain[0].hit = 1'b0;
	assign chain[0].uid = uid_bytes;
	assign tail         = chain[ENTRIES];

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		assign wr_en[k] = accept && (opcode == OP_ENROLL) && (32'(slot) == k);

		cuwm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_en[k]),
			.wr_length (uid_length),
			.wr_uid    (wr_uid),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			last_q     <= 1'b0;
			group_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			status_q   <= STATUS_NOMATCH;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				if (opcode == OP_ENROLL) begin
					m_tvalid_q <= 1'b1;
					status_q   <= STATUS_ENROLLED;
				end else begin
					busy_q <= 1'b1;
					last_q <= s_tlast;
				end
			end
			if (tail.vld) begin
				busy_q <= 1'b0;
				if (last_q) begin
					m_tvalid_q <= 1'b1;
					status_q   <= (group_q | tail.hit) ? STATUS_MATCH : STATUS_NOMATCH;
					group_q    <= 1'b0;
				end else begin
					group_q <= group_q | tail.hit;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-STATUS_W){1'b0}}, status_q};

endmodule

>>> src/cuwm_checker.sv
// Port-level checks for the card identifier whitelist, bound to the top level
module cuwm_checker #(
	parameter int ENTRIES = cuwm_pkg::CUWM_ENTRIES
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [cuwm_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cuwm_pkg::M_TDATA_W-1:0] m_tdata
);
	import cuwm_pkg::*;

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_enroll_ack: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tdata[0] == OP_ENROLL)
		|=> m_tvalid && (m_tdata[STATUS_W-1:0] == STATUS_ENROLLED))
		else $error("enroll not acknowledged");

	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tdata[0] == OP_CHECK) |=> !s_tready)
		else $error("transaction taken during a check");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tdata[0] == OP_CHECK) && s_tlast
		|-> ##(ENTRIES+1) m_tvalid && (m_tdata[STATUS_W-1:0] != STATUS_ENROLLED))
		else $error("verdict missing after check");

	a_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tdata[0] == OP_CHECK) && !s_tlast |-> ##(ENTRIES+1) !m_tvalid)
		else $error("result given for inner group member");

endmodule

bind card_uid_whitelist_match cuwm_checker #(.ENTRIES(ENTRIES)) u_cuwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the card identifier whitelist: stream driver, predictor, monitor
`timescale 1ns / 1ps

module tb;
	import cuwm_pkg::*;

	localparam int ENTRIES     = CUWM_ENTRIES;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_OFF    = 400;

	typedef struct {
		logic             op;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		logic [UID_W-1:0]  uid;
		logic              last;
	} badge_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	card_uid_whitelist_match #(.ENTRIES(ENTRIES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	badge_t badge_queue[$];
	logic [STATUS_W-1:0] status_expected[$];
	badge_t offered;

	logic             roster_valid[ENTRIES];
	logic [LEN_W-1:0] roster_len[ENTRIES];
	logic [UID_W-1:0] roster_uid[ENTRIES];
	logic             group_hit = 1'b0;

	logic             shadow_used[ENTRIES];
	logic [LEN_W-1:0] shadow_len[ENTRIES];
	logic [UID_W-1:0] shadow_uid[ENTRIES];

	int items_total    = 0;
	int items_accepted = 0;
	int enrolls_sent   = 0;
	int checks_sent    = 0;
	int results_seen   = 0;
	int verdicts_hit   = 0;
	int verdicts_miss  = 0;
	int errors         = 0;
	int stall_cycles   = 0;
	int hold_left      = 0;
	logic hold_done    = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [UID_W-1:0] lead_mask(input logic [LEN_W-1:0] n);
		if (n >= UID_BYTES)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic logic len_compared(input logic [LEN_W-1:0] n);
		return n == LEN_SHORT || n == LEN_DOUBLE || n == LEN_EIGHT;
	endfunction

	// Step the whitelist model by one item; queue a status for enrolls and last checks.
	function automatic void screen_badge(input badge_t b);
		logic hit;
		hit = 1'b0;
		if (b.op == OP_ENROLL) begin
			if (b.slot < ENTRIES) begin
				roster_valid[b.slot] = 1'b1;
				roster_len[b.slot]   = b.len;
				roster_uid[b.slot]   = b.uid & lead_mask(b.len);
			end
			status_expected.push_back(STATUS_ENROLLED);
		end else begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (roster_valid[k] && len_compared(roster_len[k]) &&
				    ((b.uid ^ roster_uid[k]) & lead_mask(roster_len[k])) == '0)
					hit = 1'b1;
			end
			group_hit = group_hit | hit;
			if (b.last) begin
				status_expected.push_back(group_hit ? STATUS_MATCH : STATUS_NOMATCH);
				group_hit = 1'b0;
			end
		end
	endfunction

	function automatic void post_badge(input logic op, input int slot, input int len,
	                                   input logic [UID_W-1:0] uid, input logic last);
		badge_t b;
		b.op   = op;
		b.slot = SLOT_W'(slot);
		b.len  = LEN_W'(len);
		b.uid  = uid;
		b.last = last;
		badge_queue.push_back(b);
		items_total++;
		if (op == OP_ENROLL) begin
			enrolls_sent++;
			shadow_used[b.slot] = 1'b1;
			shadow_len[b.slot]  = b.len;
			shadow_uid[b.slot]  = uid & lead_mask(b.len);
		end else begin
			checks_sent++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				screen_badge(offered);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (badge_queue.size() > 0 &&
				    ((items_accepted >= 300 && items_accepted < 380) ||
				     $urandom_range(0, 99) >= 33)) begin
					offered = badge_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {5'b0, offered.uid, offered.len, offered.slot, offered.op};
					s_tlast  <= offered.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [STATUS_W-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tdata[STATUS_W-1:0] == STATUS_MATCH)
					verdicts_hit++;
				else if (m_tdata[STATUS_W-1:0] == STATUS_NOMATCH)
					verdicts_miss++;
				if (status_expected.size() == 0) begin
					$error("status: no transaction expected, got %0d", m_tdata[STATUS_W-1:0]);
					errors++;
				end else begin
					want = status_expected.pop_front();
					if (m_tdata[STATUS_W-1:0] !== want) begin
						$error("status: expected %0d, got %0d", want, m_tdata[STATUS_W-1:0]);
						errors++;
					end
				end
			end
			if (!hold_done && results_seen >= 120) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (results_seen >= 200 && results_seen < 260) ||
				            $urandom_range(0, 99) >= 33;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [UID_W-1:0] uid;
		int len;
		int group;
		int k;
		int r;
		int directed;
		int lens_compared[3];

		lens_compared = '{4, 7, 8};
		for (int i = 0; i < ENTRIES; i++) begin
			roster_valid[i] = 1'b0;
			roster_len[i]   = '0;
			roster_uid[i]   = '0;
			shadow_used[i]  = 1'b0;
			shadow_len[i]   = '0;
			shadow_uid[i]   = '0;
		end

		// enroll every compared length, bytes past the length must be dropped
		post_badge(OP_ENROLL, 0, 4, 64'hFFFF_FFFF_1234_5678, 1'b1);
		post_badge(OP_ENROLL, 63, 7, 64'hEE11_2233_4455_6677, 1'b0);
		post_badge(OP_ENROLL, 5, 8, '1, 1'b1);
		// lengths that never match
		post_badge(OP_ENROLL, 6, 0, 64'h0, 1'b0);
		post_badge(OP_ENROLL, 7, 3, 64'h0000_0000_00A1_B2C3, 1'b1);
		post_badge(OP_ENROLL, 8, 5, 64'h0000_00C0_FFEE_0001, 1'b0);
		post_badge(OP_ENROLL, 9, 6, 64'h0000_ABCD_EF01_2345, 1'b0);
		// single-item groups
		post_badge(OP_CHECK, 63, 15, 64'hA5A5_A5A5_1234_5678, 1'b1);
		post_badge(OP_CHECK, 0, 0, 64'h7711_2233_4455_6677, 1'b1);
		post_badge(OP_CHECK, 1, 8, '1, 1'b1);
		post_badge(OP_CHECK, 2, 3, 64'h0000_0000_00A1_B2C3, 1'b1);
		post_badge(OP_CHECK, 3, 5, 64'h0000_00C0_FFEE_0001, 1'b1);
		post_badge(OP_CHECK, 4, 0, 64'h0, 1'b1);
		// multi-item groups
		post_badge(OP_CHECK, 0, 0, 64'h1, 1'b0);
		post_badge(OP_CHECK, 0, 0, 64'h0000_0000_1234_5678, 1'b0);
		post_badge(OP_CHECK, 0, 0, 64'h2, 1'b1);
		post_badge(OP_CHECK, 0, 0, 64'h3, 1'b0);
		post_badge(OP_CHECK, 0, 0, 64'h4, 1'b1);
		post_badge(OP_CHECK, 0, 0, 64'h0011_2233_4455_6677, 1'b0);
		post_badge(OP_ENROLL, 10, 4, 64'h0000_0000_CAFE_BABE, 1'b1);
		post_badge(OP_CHECK, 0, 0, 64'h5, 1'b1);
		// overwrite a slot so the old identifier is gone
		post_badge(OP_ENROLL, 0, 5, 64'h0000_0099_1234_5678, 1'b0);
		post_badge(OP_CHECK, 0, 0, 64'h0000_0000_1234_5678, 1'b1);
		post_badge(OP_ENROLL, 1, 8, 64'h0, 1'b0);
		post_badge(OP_CHECK, 0, 0, 64'h0, 1'b1);
		directed = items_total;

		while (items_total < directed + RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 30) begin
				len = ($urandom_range(0, 99) < 60) ? lens_compared[$urandom_range(0, 2)]
				                                    : $urandom_range(0, 8);
				post_badge(OP_ENROLL, $urandom_range(0, ENTRIES - 1), len,
				           {$urandom, $urandom}, 1'($urandom_range(0, 1)));
			end else begin
				group = $urandom_range(1, 4);
				for (int g = 0; g < group; g++) begin
					if ($urandom_range(0, 99) < 8)
						post_badge(OP_ENROLL, $urandom_range(0, ENTRIES - 1),
						           lens_compared[$urandom_range(0, 2)], {$urandom, $urandom}, 1'b0);
					uid = {$urandom, $urandom};
					r = $urandom_range(0, 99);
					k = $urandom_range(0, ENTRIES - 1);
					if (r < 55 && shadow_used[k]) begin
						uid = (uid & ~lead_mask(shadow_len[k])) | shadow_uid[k];
						if (r < 12 && len_compared(shadow_len[k]))
							uid[$urandom_range(0, 8 * shadow_len[k] - 1)] ^= 1'b1;
					end
					post_badge(OP_CHECK, $urandom_range(0, ENTRIES - 1), $urandom_range(0, 8),
					           uid, g == group - 1);
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total)
			@(negedge clk);
		while (status_expected.size() > 0)
			@(negedge clk);
		repeat (ENTRIES + 16) @(negedge clk);

		$display("covered %0d enrolls and %0d identifier checks, %0d results",
		         enrolls_sent, checks_sent, results_seen);
		$display("group verdicts: %0d matched, %0d unmatched, one long output hold-off",
		         verdicts_hit, verdicts_miss);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
src/cuwm_pkg.sv
src/cuwm_cell.sv
src/card_uid_whitelist_match.sv
src/cuwm_checker.sv
tb/sv/tb.sv
